// ===== rtl/core/via_pkg.sv =====
package via_pkg;

  localparam int EvW = 24;

  typedef logic [1:0] op_t;
  localparam op_t OP_TICK  = 2'd0;
  localparam op_t OP_READ  = 2'd1;
  localparam op_t OP_WRITE = 2'd2;
  localparam op_t OP_CA1   = 2'd3;

  typedef logic [3:0] addr_t;
  localparam addr_t R_ORB   = 4'h0;
  localparam addr_t R_ORA   = 4'h1;
  localparam addr_t R_DDRB  = 4'h2;
  localparam addr_t R_DDRA  = 4'h3;
  localparam addr_t R_T1CL  = 4'h4;
  localparam addr_t R_T1CH  = 4'h5;
  localparam addr_t R_T1LL  = 4'h6;
  localparam addr_t R_T1LH  = 4'h7;
  localparam addr_t R_T2CL  = 4'h8;
  localparam addr_t R_T2CH  = 4'h9;
  localparam addr_t R_SR    = 4'hA;
  localparam addr_t R_ACR   = 4'hB;
  localparam addr_t R_PCR   = 4'hC;
  localparam addr_t R_IFR   = 4'hD;
  localparam addr_t R_IER   = 4'hE;
  localparam addr_t R_ORA_NH = 4'hF;

  // event bit positions
  localparam int EV_CNT_A0   = 0;
  localparam int EV_CNT_A1   = 1;
  localparam int EV_CNT_B0   = 2;
  localparam int EV_CNT_B1   = 3;
  localparam int EV_RLD_A0   = 4;
  localparam int EV_RLD_A1   = 5;
  localparam int EV_RLD_A2   = 6;
  localparam int EV_POST_A   = 7;
  localparam int EV_POST_B   = 8;
  localparam int EV_IRQ0     = 9;
  localparam int EV_IRQ1     = 10;
  localparam int EV_SETCA1   = 11;
  localparam int EV_CLRCA1   = 12;
  localparam int EV_SETCA2_0 = 13;
  localparam int EV_SETCA2_1 = 14;
  localparam int EV_CLRCA2_0 = 15;
  localparam int EV_CLRCA2_1 = 16;
  localparam int EV_SETCB2_0 = 17;
  localparam int EV_SETCB2_1 = 18;
  localparam int EV_CLRCB2_0 = 19;
  localparam int EV_CLRCB2_1 = 20;
  localparam int EV_PB7      = 21;
  localparam int EV_RELIRQ0  = 22;
  localparam int EV_RELIRQ1  = 23;

  localparam logic [EvW-1:0] EV_ADVANCE = 24'h4AA235;

  localparam logic [15:0] T_RESET   = 16'h01AA;
  localparam logic [15:0] T1L_RESET = 16'h0105;
  localparam logic [7:0]  T2L_RESET = 8'hAA;

  typedef struct packed {
    op_t        op;
    addr_t      reg_addr;
    logic [7:0] write_data;
    logic [7:0] pins_a;
    logic [7:0] pins_b;
    logic       ca1_level;
  } item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       irq_out;
    logic [7:0] drive_a;
    logic [7:0] drive_b;
    logic       ca2_line;
    logic       cb2_line;
  } result_t;

  typedef struct packed {
    logic [6:0]     flags;
    logic [EvW-1:0] pipe;
  } fp_t;

  function automatic fp_t flag_set(fp_t s, logic [6:0] en, int b);
    fp_t r;
    r = s;
    r.flags = r.flags | (7'(1) << b);
    if (en[b]) r.pipe[EV_IRQ0] = 1'b1;
    return r;
  endfunction

  function automatic fp_t flag_clr(fp_t s, logic [6:0] en, int b);
    fp_t r;
    r = s;
    r.flags = r.flags & ~(7'(1) << b);
    if ((r.flags & en) == 7'd0) r.pipe[EV_RELIRQ0] = 1'b1;
    return r;
  endfunction

endpackage

// ===== rtl/core/via_core.sv =====
module via_core
  import via_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    step,
  input  item_t   item,
  output result_t res
);

  logic [7:0]     out_a_r, out_b_r, dir_a_r, dir_b_r, lat_a_r, lat_b_r;
  logic [7:0]     out_a_nxt, out_b_nxt, dir_a_nxt, dir_b_nxt, lat_a_nxt, lat_b_nxt;
  logic [15:0]    t1_r, t2_r, t1l_r, t1_nxt, t2_nxt, t1l_nxt;
  logic [7:0]     t2l_r, sr_r, acr_r, pcr_r, t2l_nxt, sr_nxt, acr_nxt, pcr_nxt;
  logic [6:0]     ier_r, ifr_r, ier_nxt;
  logic [EvW-1:0] pipe_r, feed_r, feed_nxt;
  logic [2:0]     lines_r, lines_nxt;
  logic           irq_r, irq_nxt;
  fp_t            fp;
  logic [7:0]     rd;

  function automatic logic [7:0] pa_val(logic [7:0] o, logic [7:0] d, logic [7:0] p);
    return (o & d) | (p & ~d);
  endfunction

  function automatic logic [7:0] pb_val(logic [7:0] o, logic [7:0] d, logic [7:0] p,
                                        logic [7:0] acr, logic pb7);
    logic [7:0] v;
    v = (o & d) | (p & ~d);
    if (acr[7]) v[7] = pb7;
    return v;
  endfunction

  always_comb begin
    logic [2:0] mode;
    logic       lvl;
    out_a_nxt = out_a_r; out_b_nxt = out_b_r; dir_a_nxt = dir_a_r; dir_b_nxt = dir_b_r;
    lat_a_nxt = lat_a_r; lat_b_nxt = lat_b_r;
    t1_nxt = t1_r; t2_nxt = t2_r; t1l_nxt = t1l_r; t2l_nxt = t2l_r;
    sr_nxt = sr_r; acr_nxt = acr_r; pcr_nxt = pcr_r; ier_nxt = ier_r;
    fp.flags = ifr_r; fp.pipe = pipe_r; feed_nxt = feed_r;
    lines_nxt = lines_r; irq_nxt = irq_r; rd = 8'd0;
    mode = 3'd0; lvl = 1'b0;
    unique case (item.op)
      OP_TICK: begin
        if (fp.pipe[EV_RLD_A2]) t1_nxt = t1l_r;
        else if (fp.pipe[EV_CNT_A1]) t1_nxt = t1_nxt - 16'd1;
        if (t1_nxt == 16'd0) begin
          fp.pipe[EV_RLD_A0] = 1'b1;
          if (!feed_nxt[EV_POST_A]) begin
            fp = flag_set(fp, ier_r, 6);
            feed_nxt[EV_PB7] = ~feed_nxt[EV_PB7];
          end
          if (!acr_r[6]) feed_nxt[EV_POST_A] = 1'b1;
        end
        if (fp.pipe[EV_CNT_B1]) t2_nxt = t2_nxt - 16'd1;
        if (t2_nxt == 16'd0 && fp.pipe[EV_CNT_B0] && !fp.pipe[EV_POST_B]) begin
          fp = flag_set(fp, ier_r, 5);
          feed_nxt[EV_POST_B] = 1'b1;
        end
        if (fp.pipe[EV_RELIRQ1]) irq_nxt = 1'b0;
        if (fp.pipe[EV_IRQ1]) irq_nxt = 1'b1;
        // ca1 set then clear, each an edge check against the held level
        for (int k = 0; k < 2; k++) begin
          lvl = (k == 0);
          if (fp.pipe[(k == 0) ? EV_SETCA1 : EV_CLRCA1] && lines_nxt[0] != lvl) begin
            lines_nxt[0] = lvl;
            if (pcr_r[0] ? lvl : !lvl) begin
              fp = flag_set(fp, ier_r, 1);
              if (acr_r[0]) lat_a_nxt = pa_val(out_a_r, dir_a_r, item.pins_a);
              if (pcr_r[3:1] == 3'd4) lines_nxt[1] = 1'b1;
            end
          end
        end
        if (fp.pipe[EV_SETCA2_1]) lines_nxt[1] = 1'b1;
        if (fp.pipe[EV_CLRCA2_1]) lines_nxt[1] = 1'b0;
        if (fp.pipe[EV_SETCB2_1]) lines_nxt[2] = 1'b1;
        if (fp.pipe[EV_CLRCB2_1]) lines_nxt[2] = 1'b0;
        fp.pipe = ((fp.pipe & EV_ADVANCE) << 1) | feed_nxt;
      end
      OP_READ: begin
        unique case (item.reg_addr)
          R_ORB: begin
            fp = flag_clr(fp, ier_r, 4);
            mode = pcr_r[7:5];
            if (mode == 3'd0 || mode == 3'd2) fp = flag_clr(fp, ier_r, 3);
            if (!acr_r[1])
              lat_b_nxt = pb_val(out_b_r, dir_b_r, item.pins_b, acr_r, feed_r[EV_PB7]);
            rd = lat_b_nxt;
          end
          R_ORA, R_ORA_NH: begin
            mode = pcr_r[3:1];
            fp = flag_clr(fp, ier_r, 1);
            if (mode == 3'd0 || mode == 3'd2 || mode == 3'd4 || mode == 3'd5)
              fp = flag_clr(fp, ier_r, 0);
            if (item.reg_addr == R_ORA && mode == 3'd4) fp.pipe[EV_CLRCA2_1] = 1'b1;
            if (item.reg_addr == R_ORA && mode == 3'd5) begin
              fp.pipe[EV_CLRCA2_1] = 1'b1;
              fp.pipe[EV_SETCA2_0] = 1'b1;
            end
            if (!acr_r[0]) lat_a_nxt = pa_val(out_a_r, dir_a_r, item.pins_a);
            rd = lat_a_nxt;
          end
          R_DDRB: rd = dir_b_r;
          R_DDRA: rd = dir_a_r;
          R_T1CL: begin fp = flag_clr(fp, ier_r, 6); rd = t1_r[7:0]; end
          R_T1CH: rd = t1_r[15:8];
          R_T1LL: rd = t1l_r[7:0];
          R_T1LH: rd = t1l_r[15:8];
          R_T2CL: begin fp = flag_clr(fp, ier_r, 5); rd = t2_r[7:0]; end
          R_T2CH: rd = t2_r[15:8];
          R_SR:   begin fp = flag_clr(fp, ier_r, 2); rd = sr_r; end
          R_ACR:  rd = acr_r;
          R_PCR:  rd = pcr_r;
          R_IFR:  rd = {|(ifr_r & ier_r), ifr_r};
          default: rd = {1'b1, ier_r};
        endcase
      end
      OP_WRITE: begin
        unique case (item.reg_addr)
          R_ORB: begin
            fp = flag_clr(fp, ier_r, 4);
            mode = pcr_r[7:5];
            if (mode == 3'd0 || mode == 3'd2 || mode == 3'd4 || mode == 3'd5)
              fp = flag_clr(fp, ier_r, 3);
            if (mode == 3'd4) fp.pipe[EV_CLRCB2_1] = 1'b1;
            if (mode == 3'd5) begin
              fp.pipe[EV_CLRCB2_1] = 1'b1;
              fp.pipe[EV_SETCB2_0] = 1'b1;
            end
            out_b_nxt = item.write_data;
          end
          R_ORA, R_ORA_NH: begin
            mode = pcr_r[3:1];
            fp = flag_clr(fp, ier_r, 1);
            if (mode == 3'd0 || mode == 3'd2 || mode == 3'd4 || mode == 3'd5)
              fp = flag_clr(fp, ier_r, 0);
            if (item.reg_addr == R_ORA && mode == 3'd4) fp.pipe[EV_CLRCA2_1] = 1'b1;
            if (item.reg_addr == R_ORA && mode == 3'd5) begin
              fp.pipe[EV_CLRCA2_1] = 1'b1;
              fp.pipe[EV_SETCA2_0] = 1'b1;
            end
            out_a_nxt = item.write_data;
          end
          R_DDRB: dir_b_nxt = item.write_data;
          R_DDRA: dir_a_nxt = item.write_data;
          R_T1CL, R_T1LL: t1l_nxt = {t1l_r[15:8], item.write_data};
          R_T1CH: begin
            t1l_nxt = {item.write_data, t1l_r[7:0]};
            t1_nxt = t1l_nxt;
            fp = flag_clr(fp, ier_r, 6);
            if (acr_r[7]) feed_nxt[EV_PB7] = ~feed_nxt[EV_PB7];
            fp.pipe[EV_RLD_A2] = 1'b1;
            feed_nxt[EV_POST_A] = 1'b0;
            fp.pipe[EV_POST_A] = 1'b0;
            fp.pipe[EV_CNT_A1] = 1'b0;
            fp.pipe[EV_RLD_A1] = 1'b0;
          end
          R_T1LH: begin
            t1l_nxt = {item.write_data, t1l_r[7:0]};
            fp = flag_clr(fp, ier_r, 6);
          end
          R_T2CL: t2l_nxt = item.write_data;
          R_T2CH: begin
            t2_nxt = {item.write_data, t2l_r};
            fp = flag_clr(fp, ier_r, 5);
            feed_nxt[EV_POST_B] = 1'b0;
            fp.pipe[EV_POST_B] = 1'b0;
            fp.pipe[EV_CNT_B1] = 1'b0;
          end
          R_SR: begin fp = flag_clr(fp, ier_r, 2); sr_nxt = item.write_data; end
          R_ACR: begin
            acr_nxt = item.write_data;
            fp.pipe[EV_CNT_B0] = ~item.write_data[5];
            feed_nxt[EV_CNT_B0] = ~item.write_data[5];
            if (item.write_data[7]) feed_nxt[EV_PB7] = 1'b1;
          end
          R_PCR: begin
            pcr_nxt = item.write_data;
            lines_nxt[1] = item.write_data[3:1] != 3'd6;
            lines_nxt[2] = item.write_data[7:5] != 3'd6;
          end
          R_IFR: begin
            fp.flags = fp.flags & ~item.write_data[6:0];
            irq_nxt = |(fp.flags & ier_r);
          end
          default: begin
            if (item.write_data[7]) ier_nxt = ier_r | item.write_data[6:0];
            else ier_nxt = ier_r & ~item.write_data[6:0];
            irq_nxt = |(fp.flags & ier_nxt);
          end
        endcase
      end
      default: begin
        if (item.ca1_level) fp.pipe[EV_SETCA1] = 1'b1;
        else fp.pipe[EV_CLRCA1] = 1'b1;
      end
    endcase
    res.read_data = rd;
    res.irq_out   = irq_nxt;
    res.drive_a   = pa_val(out_a_nxt, dir_a_nxt, item.pins_a);
    res.drive_b   = pb_val(out_b_nxt, dir_b_nxt, item.pins_b, acr_nxt, feed_nxt[EV_PB7]);
    res.ca2_line  = lines_nxt[1];
    res.cb2_line  = lines_nxt[2];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_a_r <= '0; out_b_r <= '0; dir_a_r <= '0; dir_b_r <= '0;
      lat_a_r <= '0; lat_b_r <= '0;
      t1_r <= T_RESET; t2_r <= T_RESET; t1l_r <= T1L_RESET; t2l_r <= T2L_RESET;
      sr_r <= '0; acr_r <= '0; pcr_r <= '0; ier_r <= '0; ifr_r <= '0;
      pipe_r <= '0;
      feed_r <= EvW'((1 << EV_CNT_A0) | (1 << EV_CNT_B0));
      lines_r <= '0; irq_r <= 1'b0;
    end else if (step) begin
      out_a_r <= out_a_nxt; out_b_r <= out_b_nxt; dir_a_r <= dir_a_nxt; dir_b_r <= dir_b_nxt;
      lat_a_r <= lat_a_nxt; lat_b_r <= lat_b_nxt;
      t1_r <= t1_nxt; t2_r <= t2_nxt; t1l_r <= t1l_nxt; t2l_r <= t2l_nxt;
      sr_r <= sr_nxt; acr_r <= acr_nxt; pcr_r <= pcr_nxt; ier_r <= ier_nxt;
      ifr_r <= fp.flags; pipe_r <= fp.pipe; feed_r <= feed_nxt;
      lines_r <= lines_nxt; irq_r <= irq_nxt;
    end
  end

endmodule

// ===== rtl/core/versatile_interface_adapter.sv =====
// throughput: one word per cycle while the receiver does not stall the output;
// each word is held in the input register, handled in a single pass of the core logic
// and then registered in the result register
// reset: synchronous active-low rst_n returns the core registers to their power-on values
// and empties both stages; the input and result data registers are not reset
module versatile_interface_adapter
  import via_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_op,
  input  logic [3:0] in_reg_addr,
  input  logic [7:0] in_write_data,
  input  logic [7:0] in_pins_a,
  input  logic [7:0] in_pins_b,
  input  logic       in_ca1_level,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_read_data,
  output logic       out_irq_out,
  output logic [7:0] out_drive_a,
  output logic [7:0] out_drive_b,
  output logic       out_ca2_line,
  output logic       out_cb2_line
);

  logic    in_vld_r, out_vld_r, step, take;
  item_t   item_r;
  result_t res, res_r;

  assign step     = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = in_vld_r && !step;
  assign take     = in_valid && !in_stall;

  via_core u_core (
    .clk  (clk),
    .rst_n(rst_n),
    .step (step),
    .item (item_r),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (take) in_vld_r <= 1'b1;
      else if (step) in_vld_r <= 1'b0;
      if (step) out_vld_r <= 1'b1;
      else if (!out_stall) out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) item_r <= {in_op, in_reg_addr, in_write_data, in_pins_a, in_pins_b, in_ca1_level};
    if (step) res_r <= res;
  end

  assign out_valid     = out_vld_r;
  assign out_read_data = res_r.read_data;
  assign out_irq_out   = res_r.irq_out;
  assign out_drive_a   = res_r.drive_a;
  assign out_drive_b   = res_r.drive_b;
  assign out_ca2_line  = res_r.ca2_line;
  assign out_cb2_line  = res_r.cb2_line;

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import via_pkg::*;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [1:0] in_op = OP_TICK;
  logic [3:0] in_reg_addr = R_ORB;
  logic [7:0] in_write_data = 8'h00;
  logic [7:0] in_pins_a = 8'h00;
  logic [7:0] in_pins_b = 8'h00;
  logic       in_ca1_level = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_read_data;
  logic       out_irq_out;
  logic [7:0] out_drive_a;
  logic [7:0] out_drive_b;
  logic       out_ca2_line;
  logic       out_cb2_line;

  versatile_interface_adapter uut (.*);

  always #5 clk = ~clk;

  // event pipe bit masks
  localparam logic [31:0] M_CNT_A0 = 32'h1 << EV_CNT_A0;
  localparam logic [31:0] M_CNT_A1 = 32'h1 << EV_CNT_A1;
  localparam logic [31:0] M_CNT_B0 = 32'h1 << EV_CNT_B0;
  localparam logic [31:0] M_CNT_B1 = 32'h1 << EV_CNT_B1;
  localparam logic [31:0] M_RLD_A0 = 32'h1 << EV_RLD_A0;
  localparam logic [31:0] M_RLD_A1 = 32'h1 << EV_RLD_A1;
  localparam logic [31:0] M_RLD_A2 = 32'h1 << EV_RLD_A2;
  localparam logic [31:0] M_POST_A = 32'h1 << EV_POST_A;
  localparam logic [31:0] M_POST_B = 32'h1 << EV_POST_B;
  localparam logic [31:0] M_IRQ0 = 32'h1 << EV_IRQ0;
  localparam logic [31:0] M_IRQ1 = 32'h1 << EV_IRQ1;
  localparam logic [31:0] M_SETCA1 = 32'h1 << EV_SETCA1;
  localparam logic [31:0] M_CLRCA1 = 32'h1 << EV_CLRCA1;
  localparam logic [31:0] M_SETCA2_0 = 32'h1 << EV_SETCA2_0;
  localparam logic [31:0] M_SETCA2_1 = 32'h1 << EV_SETCA2_1;
  localparam logic [31:0] M_CLRCA2_1 = 32'h1 << EV_CLRCA2_1;
  localparam logic [31:0] M_SETCB2_0 = 32'h1 << EV_SETCB2_0;
  localparam logic [31:0] M_SETCB2_1 = 32'h1 << EV_SETCB2_1;
  localparam logic [31:0] M_CLRCB2_1 = 32'h1 << EV_CLRCB2_1;
  localparam logic [31:0] M_PB7 = 32'h1 << EV_PB7;
  localparam logic [31:0] M_RELIRQ0 = 32'h1 << EV_RELIRQ0;
  localparam logic [31:0] M_RELIRQ1 = 32'h1 << EV_RELIRQ1;
  localparam logic [31:0] M_ADV = {8'h00, EV_ADVANCE};

  localparam int WATCHDOG = 2000;
  localparam int HOLD_CYCLES = 40;

  // predictor state
  logic [7:0]  m_ora, m_orb, m_ddra, m_ddrb, m_ila, m_ilb;
  logic [15:0] m_t1, m_t2, m_t1l;
  logic [7:0]  m_t2ll, m_sr, m_acr, m_pcr;
  logic [6:0]  m_ier, m_ifr;
  logic [31:0] m_pipe, m_feed;
  logic [2:0]  m_lines;
  logic        m_irq;

  typedef bit bool_t;

  result_t expected_words[$];
  int mismatches = 0;
  int sent = 0;
  int received = 0;
  int idle_cycles = 0;
  int rx_wait = 0;
  bool_t hold_rx = 1'b0;
  bool_t hold_go = 1'b0;

  task automatic via_reset_model();
    m_ora = 0; m_orb = 0; m_ddra = 0; m_ddrb = 0; m_ila = 0; m_ilb = 0;
    m_t1 = T_RESET; m_t2 = T_RESET; m_t1l = T1L_RESET; m_t2ll = T2L_RESET;
    m_sr = 0; m_acr = 0; m_pcr = 0; m_ier = 0; m_ifr = 0;
    m_pipe = 0; m_feed = M_CNT_A0 | M_CNT_B0; m_lines = 0; m_irq = 0;
  endtask

  task automatic raise_flag(int b);
    m_ifr[b] = 1'b1;
    if (m_ier[b]) m_pipe |= M_IRQ0;
  endtask

  task automatic drop_flag(int b);
    m_ifr[b] = 1'b0;
    if ((m_ifr & m_ier) == 7'd0) m_pipe |= M_RELIRQ0;
  endtask

  function automatic logic [7:0] port_a_level(logic [7:0] pins);
    return (m_ora & m_ddra) | (pins & ~m_ddra);
  endfunction

  function automatic logic [7:0] port_b_level(logic [7:0] pins);
    logic [7:0] v;
    v = (m_orb & m_ddrb) | (pins & ~m_ddrb);
    if (m_acr[7]) v[7] = (m_feed & M_PB7) != 0;
    return v;
  endfunction

  task automatic ora_side(bit handshake);
    logic [2:0] mode;
    mode = m_pcr[3:1];
    drop_flag(1);
    if (mode == 0 || mode == 2 || mode == 4 || mode == 5) drop_flag(0);
    if (handshake && mode == 4) m_pipe |= M_CLRCA2_1;
    if (handshake && mode == 5) m_pipe |= M_CLRCA2_1 | M_SETCA2_0;
  endtask

  task automatic ca1_edge(bit level, logic [7:0] pins);
    bit active;
    if (m_lines[0] == level) return;
    m_lines[0] = level;
    active = m_pcr[0] ? level : !level;
    if (!active) return;
    raise_flag(1);
    if (m_acr[0]) m_ila = port_a_level(pins);
    if (m_pcr[3:1] == 4) m_lines[1] = 1'b1;
  endtask

  task automatic advance_clock(logic [7:0] pins);
    if (m_pipe & M_RLD_A2) m_t1 = m_t1l;
    else if (m_pipe & M_CNT_A1) m_t1 = m_t1 - 16'd1;
    if (m_t1 == 0) begin
      m_pipe |= M_RLD_A0;
      if (!(m_feed & M_POST_A)) begin
        raise_flag(6);
        m_feed ^= M_PB7;
      end
      if (!m_acr[6]) m_feed |= M_POST_A;
    end
    if (m_pipe & M_CNT_B1) m_t2 = m_t2 - 16'd1;
    if (m_t2 == 0 && (m_pipe & M_CNT_B0) && !(m_pipe & M_POST_B)) begin
      raise_flag(5);
      m_feed |= M_POST_B;
    end
    if (m_pipe & M_RELIRQ1) m_irq = 0;
    if (m_pipe & M_IRQ1) m_irq = 1;
    if (m_pipe & M_SETCA1) ca1_edge(1'b1, pins);
    if (m_pipe & M_CLRCA1) ca1_edge(1'b0, pins);
    if (m_pipe & M_SETCA2_1) m_lines[1] = 1'b1;
    if (m_pipe & M_CLRCA2_1) m_lines[1] = 1'b0;
    if (m_pipe & M_SETCB2_1) m_lines[2] = 1'b1;
    if (m_pipe & M_CLRCB2_1) m_lines[2] = 1'b0;
    m_pipe = ((m_pipe & M_ADV) << 1) | m_feed;
  endtask

  task automatic bus_read(logic [3:0] addr, logic [7:0] pa, logic [7:0] pb,
                          output logic [7:0] rd);
    logic [2:0] mode;
    rd = 0;
    case (addr)
      R_ORB: begin
        drop_flag(4);
        mode = m_pcr[7:5];
        if (mode == 0 || mode == 2) drop_flag(3);
        if (!m_acr[1]) m_ilb = port_b_level(pb);
        rd = m_ilb;
      end
      R_ORA, R_ORA_NH: begin
        ora_side(addr == R_ORA);
        if (!m_acr[0]) m_ila = port_a_level(pa);
        rd = m_ila;
      end
      R_DDRB: rd = m_ddrb;
      R_DDRA: rd = m_ddra;
      R_T1CL: begin drop_flag(6); rd = m_t1[7:0]; end
      R_T1CH: rd = m_t1[15:8];
      R_T1LL: rd = m_t1l[7:0];
      R_T1LH: rd = m_t1l[15:8];
      R_T2CL: begin drop_flag(5); rd = m_t2[7:0]; end
      R_T2CH: rd = m_t2[15:8];
      R_SR: begin drop_flag(2); rd = m_sr; end
      R_ACR: rd = m_acr;
      R_PCR: rd = m_pcr;
      R_IFR: rd = {|(m_ifr & m_ier), m_ifr};
      default: rd = {1'b1, m_ier};
    endcase
  endtask

  task automatic bus_write(logic [3:0] addr, logic [7:0] v);
    logic [2:0] mode;
    case (addr)
      R_ORB: begin
        drop_flag(4);
        mode = m_pcr[7:5];
        if (mode == 0 || mode == 2 || mode == 4 || mode == 5) drop_flag(3);
        if (mode == 4) m_pipe |= M_CLRCB2_1;
        if (mode == 5) m_pipe |= M_CLRCB2_1 | M_SETCB2_0;
        m_orb = v;
      end
      R_ORA, R_ORA_NH: begin ora_side(addr == R_ORA); m_ora = v; end
      R_DDRB: m_ddrb = v;
      R_DDRA: m_ddra = v;
      R_T1CL, R_T1LL: m_t1l[7:0] = v;
      R_T1CH: begin
        m_t1l[15:8] = v;
        m_t1 = m_t1l;
        drop_flag(6);
        if (m_acr[7]) m_feed ^= M_PB7;
        m_pipe |= M_RLD_A2;
        m_feed &= ~M_POST_A;
        m_pipe &= ~(M_POST_A | M_CNT_A1 | M_RLD_A1);
      end
      R_T1LH: begin m_t1l[15:8] = v; drop_flag(6); end
      R_T2CL: m_t2ll = v;
      R_T2CH: begin
        m_t2 = {v, m_t2ll};
        drop_flag(5);
        m_feed &= ~M_POST_B;
        m_pipe &= ~(M_POST_B | M_CNT_B1);
      end
      R_SR: begin drop_flag(2); m_sr = v; end
      R_ACR: begin
        m_acr = v;
        if (v[5]) begin m_pipe &= ~M_CNT_B0; m_feed &= ~M_CNT_B0; end
        else begin m_pipe |= M_CNT_B0; m_feed |= M_CNT_B0; end
        if (v[7]) m_feed |= M_PB7;
      end
      R_PCR: begin
        m_pcr = v;
        m_lines[1] = v[3:1] != 6;
        m_lines[2] = v[7:5] != 6;
      end
      R_IFR: begin
        m_ifr = m_ifr & ~v[6:0];
        m_irq = |(m_ifr & m_ier);
      end
      default: begin
        if (v[7]) m_ier = m_ier | v[6:0];
        else m_ier = m_ier & ~v[6:0];
        m_irq = |(m_ifr & m_ier);
      end
    endcase
  endtask

  task automatic predict_word(item_t it);
    result_t r;
    logic [7:0] rd;
    rd = 0;
    case (it.op)
      OP_TICK: advance_clock(it.pins_a);
      OP_READ: bus_read(it.reg_addr, it.pins_a, it.pins_b, rd);
      OP_WRITE: bus_write(it.reg_addr, it.write_data);
      default: m_pipe |= it.ca1_level ? M_SETCA1 : M_CLRCA1;
    endcase
    r.read_data = rd;
    r.irq_out = m_irq;
    r.drive_a = port_a_level(it.pins_a);
    r.drive_b = port_b_level(it.pins_b);
    r.ca2_line = m_lines[1];
    r.cb2_line = m_lines[2];
    expected_words.push_back(r);
  endtask

  // sends one word after a random gap
  task automatic send_word(logic [1:0] op, logic [3:0] addr, logic [7:0] data,
                           logic [7:0] pa, logic [7:0] pb, logic ca1);
    int gap;
    item_t it;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
    if ($urandom_range(0, 2) == 0) gap = 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op <= op; in_reg_addr <= addr; in_write_data <= data;
    in_pins_a <= pa; in_pins_b <= pb; in_ca1_level <= ca1;
    it.op = op; it.reg_addr = addr; it.write_data = data;
    it.pins_a = pa; it.pins_b = pb; it.ca1_level = ca1;
    do @(posedge clk); while (in_stall);
    predict_word(it);
    sent++;
  endtask

  task automatic rand_word(logic [1:0] op, logic [3:0] addr, logic [7:0] data);
    send_word(op, addr, data, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
              1'($urandom_range(0, 1)));
  endtask

  task automatic ticks(int n);
    repeat (n) rand_word(OP_TICK, R_ORB, 8'h00);
  endtask

  task automatic test_directed();
    send_word(OP_READ, R_ORB, 8'h00, 8'hFF, 8'h00, 1'b0);
    rand_word(OP_WRITE, R_DDRA, 8'hFF);
    rand_word(OP_WRITE, R_ORA, 8'hA5);
    send_word(OP_READ, R_ORA, 8'h00, 8'h00, 8'hFF, 1'b1);
    rand_word(OP_WRITE, R_DDRB, 8'h0F);
    rand_word(OP_WRITE, R_IER, 8'hFF);
    rand_word(OP_WRITE, R_ACR, 8'hC3);
    rand_word(OP_WRITE, R_T1LL, 8'h03);
    rand_word(OP_WRITE, R_T1CH, 8'h00);
    ticks(6);
    rand_word(OP_READ, R_IFR, 8'h00);
    rand_word(OP_READ, R_T1CL, 8'h00);
    // ca1 edge applies on the next tick
    send_word(OP_CA1, R_ORB, 8'h00, 8'h3C, 8'h00, 1'b1);
    ticks(2);
    // cb2 pulse mode
    rand_word(OP_WRITE, R_PCR, 8'hA8);
    rand_word(OP_WRITE, R_ORB, 8'h55);
    ticks(3);
    rand_word(OP_WRITE, R_IFR, 8'h7F);
  endtask

  task automatic test_timers();
    rand_word(OP_WRITE, R_ACR, 8'h00);
    rand_word(OP_WRITE, R_T2CL, 8'h04);
    rand_word(OP_WRITE, R_T2CH, 8'h00);
    rand_word(OP_WRITE, R_T1LL, 8'h05);
    rand_word(OP_WRITE, R_T1CH, 8'h00);
    ticks(20);
    rand_word(OP_READ, R_IFR, 8'h00);
    rand_word(OP_READ, R_T2CL, 8'h00);
    rand_word(OP_WRITE, R_ACR, 8'hE0);
    rand_word(OP_WRITE, R_T1CH, 8'h00);
    ticks(12);
  endtask

  task automatic test_random(int n);
    logic [3:0] addr;
    logic [7:0] data;
    int k;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 9);
      addr = 4'($urandom_range(0, 15));
      data = 8'($urandom_range(0, 255));
      // small timer values keep underflows frequent
      if ((addr == R_T1CH || addr == R_T2CH || addr == R_T1LH) && data[0])
        data = 8'h00;
      if (k < 4) rand_word(OP_TICK, addr, data);
      else if (k < 6) rand_word(OP_READ, addr, data);
      else if (k < 9) rand_word(OP_WRITE, addr, data);
      else rand_word(OP_CA1, addr, data);
    end
  endtask

  task automatic test_backpressure();
    hold_go = 1'b1;
    ticks(30);
  endtask

  // long receiver hold-off, counted here
  initial begin
    wait (hold_go);
    @(posedge clk);
    hold_rx <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_rx <= 1'b0;
  end

  // receiver waits a random number of cycles before each word
  always @(posedge clk) begin
    int w;
    if (!rst_n) begin
      out_stall <= 1'b0;
      rx_wait <= 0;
    end else if (hold_rx) begin
      out_stall <= 1'b1;
    end else if (out_valid && !out_stall) begin
      w = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 11) : 0;
      rx_wait <= w;
      out_stall <= (w != 0);
    end else if (rx_wait > 1) begin
      rx_wait <= rx_wait - 1;
      out_stall <= 1'b1;
    end else begin
      rx_wait <= 0;
      out_stall <= 1'b0;
    end
  end

  // result checker
  always @(posedge clk) begin
    result_t got, want;
    if (rst_n && out_valid && !out_stall) begin
      received++;
      got.read_data = out_read_data; got.irq_out = out_irq_out;
      got.drive_a = out_drive_a; got.drive_b = out_drive_b;
      got.ca2_line = out_ca2_line; got.cb2_line = out_cb2_line;
      if (expected_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word %h", got);
      end else begin
        want = expected_words.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: expected rd=%h irq=%b a=%h b=%h ca2=%b cb2=%b",
                     want.read_data, want.irq_out, want.drive_a, want.drive_b,
                     want.ca2_line, want.cb2_line);
            $display("          got      rd=%h irq=%b a=%h b=%h ca2=%b cb2=%b",
                     got.read_data, got.irq_out, got.drive_a, got.drive_b,
                     got.ca2_line, got.cb2_line);
          end
        end
      end
    end
  end

  // watchdog on cycles with no handshake
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    via_reset_model();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_timers();
    test_backpressure();
    test_random(980);
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("sent %0d words, checked %0d results, %0d mismatches", sent, received,
             mismatches);
    $display("covered port i/o, timers, ca1/ca2/cb2 control, irq logic and back-pressure");
    if (mismatches == 0 && expected_words.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
